// ===== src/ata_pkg.sv =====
package ata_pkg;

	typedef enum logic [3:0] {
		KIND_IDENTITY = 4'd0,
		KIND_FILL     = 4'd1,
		KIND_TRANSLATE = 4'd2,
		KIND_ROT_X    = 4'd3,
		KIND_ROT_Y    = 4'd4,
		KIND_ROT_Z    = 4'd5,
		KIND_SCALE    = 4'd6,
		KIND_YPR      = 4'd7,
		KIND_READ     = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CORDIC,
		ST_ROUND,
		ST_ELEM,
		ST_READ
	} state_t;

	localparam logic signed [31:0] Q_ONE = 32'sd65536;
	localparam logic signed [31:0] DEG_360 = 32'sd23592960;
	localparam logic signed [31:0] DEG_180 = 32'sd11796480;
	localparam logic signed [31:0] DEG_90 = 32'sd5898240;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int CORDIC_STEPS = 16;

	function automatic logic signed [23:0] atan_deg(input logic [3:0] i);
		logic signed [23:0] r;
		case (i)
			4'd0: r = 24'sd2949120;
			4'd1: r = 24'sd1740967;
			4'd2: r = 24'sd919879;
			4'd3: r = 24'sd466945;
			4'd4: r = 24'sd234379;
			4'd5: r = 24'sd117304;
			4'd6: r = 24'sd58666;
			4'd7: r = 24'sd29335;
			4'd8: r = 24'sd14668;
			4'd9: r = 24'sd7334;
			4'd10: r = 24'sd3667;
			4'd11: r = 24'sd1833;
			4'd12: r = 24'sd917;
			4'd13: r = 24'sd458;
			4'd14: r = 24'sd229;
			default: r = 24'sd115;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat_round(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = (v + 66'sd32768) >>> 16;
		if (t > 66'sd2147483647) return 32'sh7fffffff;
		if (t < -66'sd2147483648) return 32'sh80000000;
		return t[31:0];
	endfunction

endpackage

// ===== src/affine_transform_accumulator.sv =====
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tuser: kind[3:0]; tdata: x_value[31:0] y_value[63:32] z_value[95:64]
// m_axis  | out | tdata: row[1:0] column[3:2] element[35:4]; tlast = last
// One shared 32x32 multiplier and one CORDIC adder stage under a sequencer.
// Rotations: accept, reduce, CORDIC, round, then 8 elements of two products each.
// Read: 16 elements, stalls on m_axis. Identity/fill: at accept. Translate/scale: 1 mul/elem.
// YPR runs three rotations back to back. Reset restores the identity matrix.
module affine_transform_accumulator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata, // x_value, y_value, z_value
	input  logic [3:0]   s_axis_tuser, // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata, // row, column, element
	output logic         m_axis_tlast
);

	ata_pkg::state_t state_q, state_d;
	logic [3:0] kind_q;
	logic signed [31:0] v_q [3];
	logic signed [31:0] mat_q [16];
	logic [1:0] rot_q; // ypr phase
	logic signed [33:0] r_q;
	logic neg_q;
	logic signed [33:0] cx_q, cy_q;
	logic [3:0] it_q;
	logic signed [31:0] s_q, c_q;
	logic [3:0] idx_q;
	logic ph_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] a_new_q;

	// rotation rows for current phase
	logic [1:0] ra, rb;
	logic signed [31:0] ang;
	always_comb begin
		ra = 2'd1; rb = 2'd2; ang = v_q[0];
		case (kind_q)
			ata_pkg::KIND_ROT_Y: begin ra = 2'd2; rb = 2'd0; ang = v_q[1]; end
			ata_pkg::KIND_ROT_Z: begin ra = 2'd0; rb = 2'd1; ang = v_q[2]; end
			ata_pkg::KIND_YPR: begin
				case (rot_q)
					2'd0: begin ra = 2'd0; rb = 2'd1; ang = v_q[2]; end
					2'd1: begin ra = 2'd1; rb = 2'd2; ang = v_q[0]; end
					default: begin ra = 2'd2; rb = 2'd0; ang = v_q[1]; end
				endcase
			end
			default: ;
		endcase
	end

	logic is_rot;
	assign is_rot = kind_q == ata_pkg::KIND_ROT_X || kind_q == ata_pkg::KIND_ROT_Y ||
		kind_q == ata_pkg::KIND_ROT_Z || kind_q == ata_pkg::KIND_YPR;

	// element operands: rotations walk idx[1:0] 0..3 over columns; others idx 0..11
	logic [3:0] ia, ib;
	logic signed [31:0] ma, mb, opa, opb;
	logic signed [63:0] prod;
	always_comb begin
		ia = {ra, idx_q[1:0]};
		ib = {rb, idx_q[1:0]};
		if (!is_rot) begin
			ia = idx_q;
			ib = {2'd3, idx_q[1:0]};
		end
		ma = mat_q[ia];
		mb = mat_q[ib];
		opa = ma; opb = c_q;
		case (kind_q)
			ata_pkg::KIND_TRANSLATE: begin
				opa = mb; opb = v_q[idx_q[3:2]];
			end
			ata_pkg::KIND_SCALE: begin
				opa = ma; opb = v_q[idx_q[3:2]];
			end
			default: begin
				// ph0: a*c - b*s ; ph1: a*s + b*c -- done via two products each
				opa = idx_q[2] ? mb : ma;
				opb = (idx_q[2] ^ ph_q) ? s_q : c_q;
			end
		endcase
		prod = opa * opb;
	end

	// angle reduction: |angle| mod 360 by compare-subtract, then sign and fold
	logic signed [33:0] ang_mag, dstep, rr;
	logic nn;
	always_comb begin
		ang_mag = (ang < 0) ? -34'(ang) : 34'(ang);
		dstep = 34'(ata_pkg::DEG_360) <<< (3'd7 - it_q[2:0]);
		rr = neg_q ? -r_q : r_q;
		nn = 1'b0;
		if (rr < 0) rr = rr + 34'(ata_pkg::DEG_360);
		if (rr >= 34'(ata_pkg::DEG_180)) rr = rr - 34'(ata_pkg::DEG_360);
		if (rr > 34'(ata_pkg::DEG_90)) begin
			rr = rr - 34'(ata_pkg::DEG_180); nn = 1'b1;
		end else if (rr < -34'(ata_pkg::DEG_90)) begin
			rr = rr + 34'(ata_pkg::DEG_180); nn = 1'b1;
		end
	end

	logic signed [33:0] xs, ys, cxr, cyr;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	always_comb begin
		cxr = (cx_q + 34'sd8192) >>> 14;
		cyr = (cy_q + 34'sd8192) >>> 14;
		if (neg_q) begin
			cxr = -cxr; cyr = -cyr;
		end
	end

	logic out_busy;
	assign out_busy = m_axis_tvalid && !m_axis_tready;
	assign s_axis_tready = state_q == ata_pkg::ST_IDLE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ata_pkg::ST_IDLE: if (s_axis_tvalid) begin
				case (s_axis_tuser)
					ata_pkg::KIND_ROT_X, ata_pkg::KIND_ROT_Y, ata_pkg::KIND_ROT_Z,
					ata_pkg::KIND_YPR: state_d = ata_pkg::ST_REDUCE;
					ata_pkg::KIND_TRANSLATE, ata_pkg::KIND_SCALE: state_d = ata_pkg::ST_ELEM;
					ata_pkg::KIND_READ: state_d = ata_pkg::ST_READ;
					default: state_d = ata_pkg::ST_IDLE;
				endcase
			end
			ata_pkg::ST_REDUCE: if (it_q == 4'd8) state_d = ata_pkg::ST_CORDIC;
			ata_pkg::ST_CORDIC: if (it_q == 4'd15) state_d = ata_pkg::ST_ROUND;
			ata_pkg::ST_ROUND: state_d = ata_pkg::ST_ELEM;
			ata_pkg::ST_ELEM: begin
				if (is_rot) begin
					if (idx_q == 4'd7 && ph_q) begin
						if (kind_q == ata_pkg::KIND_YPR && rot_q != 2'd2)
							state_d = ata_pkg::ST_REDUCE;
						else
							state_d = ata_pkg::ST_IDLE;
					end
				end else if (idx_q == 4'd11 && ph_q) state_d = ata_pkg::ST_IDLE;
			end
			ata_pkg::ST_READ: if (!out_busy && idx_q == 4'd15) state_d = ata_pkg::ST_IDLE;
			default: state_d = ata_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ata_pkg::ST_IDLE;
			for (int i = 0; i < 16; i++) mat_q[i] <= (i % 5 == 0) ? ata_pkg::Q_ONE : 32'sd0;
			for (int i = 0; i < 3; i++) v_q[i] <= '0;
			kind_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
			idx_q <= '0;
			ph_q <= 1'b0;
			rot_q <= '0;
			it_q <= '0;
			r_q <= '0;
			neg_q <= 1'b0;
			cx_q <= '0;
			cy_q <= '0;
			s_q <= '0;
			c_q <= '0;
			acc_q <= '0;
			a_new_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ata_pkg::ST_READ && !out_busy) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ata_pkg::ST_IDLE: begin
					idx_q <= '0; ph_q <= 1'b0; rot_q <= '0; it_q <= '0;
					if (s_axis_tvalid) begin
						kind_q <= s_axis_tuser;
						v_q[0] <= s_axis_tdata[31:0];
						v_q[1] <= s_axis_tdata[63:32];
						v_q[2] <= s_axis_tdata[95:64];
						if (s_axis_tuser == ata_pkg::KIND_IDENTITY)
							for (int i = 0; i < 16; i++)
								mat_q[i] <= (i % 5 == 0) ? ata_pkg::Q_ONE : 32'sd0;
						if (s_axis_tuser == ata_pkg::KIND_FILL)
							for (int i = 0; i < 16; i++) mat_q[i] <= s_axis_tdata[31:0];
					end
				end
				ata_pkg::ST_REDUCE: begin
					if (it_q == 4'd0) begin
						r_q <= ang_mag; neg_q <= ang < 0;
						it_q <= it_q + 4'd1;
					end else if (it_q != 4'd8) begin
						if (r_q >= dstep) r_q <= r_q - dstep;
						it_q <= it_q + 4'd1;
					end else begin
						r_q <= rr; neg_q <= nn;
						cx_q <= ata_pkg::CORDIC_GAIN; cy_q <= '0; it_q <= '0;
					end
				end
				ata_pkg::ST_CORDIC: begin
					it_q <= it_q + 4'd1;
					if (r_q >= 0) begin
						cx_q <= cx_q - ys; cy_q <= cy_q + xs;
						r_q <= r_q - 34'(ata_pkg::atan_deg(it_q));
					end else begin
						cx_q <= cx_q + ys; cy_q <= cy_q - xs;
						r_q <= r_q + 34'(ata_pkg::atan_deg(it_q));
					end
				end
				ata_pkg::ST_ROUND: begin
					c_q <= cxr[31:0]; s_q <= cyr[31:0];
					idx_q <= '0; ph_q <= 1'b0;
				end
				ata_pkg::ST_ELEM: begin
					if (is_rot) begin
						// idx[1:0]=column, idx[2]=operand b, ph selects output row
						if (!idx_q[2]) begin
							acc_q <= 66'(prod);
							idx_q <= idx_q + 4'd4;
						end else begin
							if (!ph_q) begin
								a_new_q <= ata_pkg::sat_round(acc_q - 66'(prod));
								idx_q <= idx_q - 4'd4;
								ph_q <= 1'b1;
							end else begin
								mat_q[ia] <= a_new_q;
								mat_q[ib] <= ata_pkg::sat_round(acc_q + 66'(prod));
								idx_q <= idx_q - 4'd3;
								ph_q <= 1'b0;
								if (idx_q == 4'd7) begin
									rot_q <= rot_q + 2'd1;
								end
							end
						end
					end else begin
						ph_q <= !ph_q;
						if (!ph_q) acc_q <= 66'(prod);
						else begin
							if (kind_q == ata_pkg::KIND_TRANSLATE)
								mat_q[ia] <= ata_pkg::sat_round(
									(66'(ma) <<< 16) + acc_q);
							else
								mat_q[ia] <= ata_pkg::sat_round(acc_q);
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				ata_pkg::ST_READ: if (!out_busy) begin
					m_axis_tdata <= {4'd0, mat_q[idx_q], idx_q[1:0], idx_q[3:2]};
					m_axis_tlast <= idx_q == 4'd15;
					idx_q <= idx_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

endmodule
